[sv/pfba_pkg.sv]
// Package for the page frame bitmap allocator: widths, codes, payload structs.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package pfba_pkg;

  // Fixed geometry of the map
  localparam int unsigned PageShift = 12;          // 4096-byte pages
  localparam int unsigned RowShift  = 6;           // 64 frames per row
  localparam int unsigned RowW      = 64;
  localparam int unsigned MaxRows   = 256;

  // Field widths
  localparam int unsigned CfgW       = 26;
  localparam int unsigned FrameW     = 14;
  localparam int unsigned AddrW      = 40;
  localparam int unsigned FrameCntW  = 15;         // frame counts up to 16385
  localparam int unsigned RowCalcW   = 10;         // row count before saturation
  localparam int unsigned FullW      = 9;          // full rows of the reserved area
  localparam int unsigned CfgIdxW    = 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMemSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgResvEnd = 1'b1;

  typedef enum logic [1:0] {
    FUNC_INIT      = 2'd0,
    FUNC_FIND      = 2'd1,
    FUNC_MARK      = 2'd2,
    FUNC_MARK_ADDR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_FIND,
    ST_MARK
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [FrameW-1:0]  frame_number;
    logic [AddrW-1:0]   address;
  } cmd_t;

  typedef struct packed {
    logic               frame_found;
    logic [FrameW-1:0]  frame_index;
    logic               ignored;
  } rsp_t;

  typedef struct packed {
    logic [CfgW-1:0] memory_size_bytes;
    logic [CfgW-1:0] reserved_end_address;
  } cfg_t;

endpackage

[sv/pfba_map_ram.sv]
// Bitmap store: one row of frame bits per entry, one write and one read port.
// Read data is registered. Uses pfba_pkg.
`timescale 1ns / 1ps

module pfba_map_ram #(
  parameter int unsigned MAX_ROWS = pfba_pkg::MaxRows,
  localparam int unsigned RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [RowIdxW-1:0]        waddr_i,
  input  logic [pfba_pkg::RowW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [RowIdxW-1:0]        raddr_i,
  output logic [pfba_pkg::RowW-1:0] rdata_o
);

  logic [pfba_pkg::RowW-1:0] mem [MAX_ROWS];
  logic [pfba_pkg::RowW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pfba_ctrl.sv]
// Sequencer of the allocator: init sweep, first-fit scan, read-modify-write marks.
// Drives the ports of pfba_map_ram and holds the row count. Uses pfba_pkg.
`timescale 1ns / 1ps

module pfba_ctrl #(
  parameter int unsigned MAX_ROWS = pfba_pkg::MaxRows,
  localparam int unsigned RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned RowCntW = $clog2(MAX_ROWS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pfba_pkg::cmd_t            cmd_i,
  input  pfba_pkg::cfg_t            cfg_i,
  output logic                      done_o,
  output pfba_pkg::rsp_t            rsp_o,
  output logic                      mem_we_o,
  output logic [RowIdxW-1:0]        mem_waddr_o,
  output logic [pfba_pkg::RowW-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [RowIdxW-1:0]        mem_raddr_o,
  input  logic [pfba_pkg::RowW-1:0] mem_rdata_i
);

  localparam int unsigned BitW = pfba_pkg::RowShift;

  // Lowest set bit of a row
  function automatic logic [BitW-1:0] lowest_set(input logic [pfba_pkg::RowW-1:0] v);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = pfba_pkg::RowW - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BitW'(i);
      end
    end
    return pos;
  endfunction

  pfba_pkg::state_e state_q, state_d;
  logic [RowCntW-1:0] cnt_q, cnt_d;
  logic [RowCntW-1:0] rows_q, rows_d;
  logic [BitW-1:0]    bit_q, bit_d;
  logic               done_q, done_d;
  pfba_pkg::rsp_t     res_q, res_d;

  logic [pfba_pkg::FrameCntW-1:0] frames_w, used_w;
  logic [pfba_pkg::RowCalcW-1:0]  rows_calc_w;
  logic [RowCntW-1:0]             rows_sat_w;
  logic [pfba_pkg::FullW-1:0]     full_w;
  logic [BitW-1:0]                rem_w;
  logic [pfba_pkg::RowW-1:0]      init_row_w;
  logic [pfba_pkg::FrameW-1:0]    mark_frame_w;
  logic [pfba_pkg::FrameW-BitW-1:0] mark_row_w;
  logic                           addr_ok_w, in_range_w, last_w, free_hit_w;
  logic [pfba_pkg::RowW-1:0]      free_w;

  // Row count from memory size, saturated at the store depth
  assign frames_w = pfba_pkg::FrameCntW'(cfg_i.memory_size_bytes >> pfba_pkg::PageShift)
                    + pfba_pkg::FrameCntW'(1);
  assign rows_calc_w = pfba_pkg::RowCalcW'(frames_w >> pfba_pkg::RowShift)
                       + pfba_pkg::RowCalcW'(1);
  assign rows_sat_w = (32'(rows_calc_w) > 32'(MAX_ROWS)) ? RowCntW'(MAX_ROWS)
                                                         : RowCntW'(rows_calc_w);

  // Reserved area: through the end address's frame, plus one if not page aligned
  assign used_w = pfba_pkg::FrameCntW'(cfg_i.reserved_end_address >> pfba_pkg::PageShift)
                  + pfba_pkg::FrameCntW'(1)
                  + pfba_pkg::FrameCntW'(
                      cfg_i.reserved_end_address[pfba_pkg::PageShift-1:0] != '0);
  assign full_w = pfba_pkg::FullW'(used_w >> pfba_pkg::RowShift);
  assign rem_w  = used_w[BitW-1:0];

  always_comb begin
    if (32'(cnt_q) < 32'(full_w)) begin
      init_row_w = '1;
    end else if (32'(cnt_q) == 32'(full_w)) begin
      init_row_w = (pfba_pkg::RowW'(1) << rem_w) - pfba_pkg::RowW'(1);
    end else begin
      init_row_w = '0;
    end
  end

  // Mark target
  assign mark_frame_w = (cmd_i.func == pfba_pkg::FUNC_MARK) ? cmd_i.frame_number
                        : pfba_pkg::FrameW'(cmd_i.address >> pfba_pkg::PageShift);
  assign mark_row_w = mark_frame_w[pfba_pkg::FrameW-1:BitW];
  assign addr_ok_w  = cmd_i.address < pfba_pkg::AddrW'(cfg_i.memory_size_bytes);
  assign in_range_w = (32'(mark_row_w) < 32'(rows_q))
                      && ((cmd_i.func == pfba_pkg::FUNC_MARK) || addr_ok_w);

  assign last_w     = (cnt_q == rows_q - RowCntW'(1));
  assign free_w     = ~mem_rdata_i;
  assign free_hit_w = (free_w != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfba_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd_i.func)
            pfba_pkg::FUNC_INIT: state_d = pfba_pkg::ST_INIT;
            pfba_pkg::FUNC_FIND: begin
              state_d = (rows_q == '0) ? pfba_pkg::ST_IDLE : pfba_pkg::ST_FIND;
            end
            default: state_d = in_range_w ? pfba_pkg::ST_MARK : pfba_pkg::ST_IDLE;
          endcase
        end
      end
      pfba_pkg::ST_INIT: begin
        if (last_w) state_d = pfba_pkg::ST_IDLE;
      end
      pfba_pkg::ST_FIND: begin
        if (free_hit_w || last_w) state_d = pfba_pkg::ST_IDLE;
      end
      pfba_pkg::ST_MARK: state_d = pfba_pkg::ST_IDLE;
      default: state_d = pfba_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cnt_d       = cnt_q;
    rows_d      = rows_q;
    bit_d       = bit_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[RowIdxW-1:0];
    mem_wdata_o = init_row_w;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[RowIdxW-1:0];
    case (state_q)
      pfba_pkg::ST_IDLE: begin
        if (start) begin
          cnt_d = '0;
          res_d = '0;
          case (cmd_i.func)
            pfba_pkg::FUNC_INIT: rows_d = rows_sat_w;
            pfba_pkg::FUNC_FIND: begin
              if (rows_q == '0) begin
                done_d = 1'b1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
              end
            end
            default: begin
              if (in_range_w) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = mark_row_w[RowIdxW-1:0];
                cnt_d       = RowCntW'(mark_row_w);
                bit_d       = mark_frame_w[BitW-1:0];
              end else begin
                done_d        = 1'b1;
                res_d.ignored = 1'b1;
              end
            end
          endcase
        end
      end
      pfba_pkg::ST_INIT: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + RowCntW'(1);
        done_d   = last_w;
      end
      pfba_pkg::ST_FIND: begin
        // Fetch the next row while checking this one
        mem_re_o    = 1'b1;
        mem_raddr_o = RowIdxW'(cnt_q + RowCntW'(1));
        if (free_hit_w) begin
          done_d            = 1'b1;
          res_d.frame_found = 1'b1;
          res_d.frame_index = pfba_pkg::FrameW'({cnt_q, lowest_set(free_w)});
        end else if (last_w) begin
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q + RowCntW'(1);
        end
      end
      pfba_pkg::ST_MARK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i | (pfba_pkg::RowW'(1) << bit_q);
        done_d      = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfba_pkg::ST_IDLE;
      cnt_q   <= '0;
      rows_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rows_q  <= rows_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != pfba_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = res_q;

endmodule

[sv/page_frame_bitmap_allocator_top.sv]
// Top level of the page frame bitmap allocator: configuration registers,
// sequencer and bitmap store. Depends on pfba_pkg, pfba_ctrl, pfba_map_ram.
`timescale 1ns / 1ps

// Channel   | Ports                               | Transfer
// ----------+-------------------------------------+------------------------------------
// command   | start, busy, cmd_i                  | rising edge with start high, busy low
// result    | done_o, rsp_o                       | one cycle strobe on done_o
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i    | any edge with cfg_we_i high
//
// From command transfer to result strobe: a mark reads the row, then writes it back;
// an init writes one row per cycle; a find fetches one row per cycle through the single
// read port of the store, up to the row holding the first clear bit, or through every
// row when none is clear.
// A mark outside memory or outside the rows, and a find with no rows, are answered
// without touching the store; busy stays low for them.
// busy drops in the cycle the result is strobed, so the next command may follow then.
// Reset clears the row count and configuration; the store itself needs no clearing,
// as only rows below the row count are ever used and init writes all of them.
// The receiver cannot stall: every result is taken in its strobe cycle.

module page_frame_bitmap_allocator_top #(
  parameter int unsigned MAX_ROWS = pfba_pkg::MaxRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pfba_pkg::cmd_t               cmd_i,
  output logic                         done_o,
  output pfba_pkg::rsp_t               rsp_o,
  input  logic                         cfg_we_i,
  input  logic [pfba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pfba_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  pfba_pkg::cfg_t cfg_q, cfg_d;

  logic                      mem_we, mem_re;
  logic [RowIdxW-1:0]        mem_waddr, mem_raddr;
  logic [pfba_pkg::RowW-1:0] mem_wdata, mem_rdata;

  // Configuration writes: hold the value until the next write to that index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pfba_pkg::CfgMemSize: cfg_d.memory_size_bytes    = cfg_wdata_i;
        pfba_pkg::CfgResvEnd: cfg_d.reserved_end_address = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer: decode commands, walk rows, drive the store
  pfba_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_q),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Bitmap store, one row per entry
  pfba_map_ram #(
    .MAX_ROWS (MAX_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[tb/sv/page_frame_bitmap_allocator_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for page_frame_bitmap_allocator_top: a bitmap tracker
// predicts every command, a monitor checks each strobed result against it.
// Depends on pfba_pkg (payload structs, codes, geometry) and the top level only.

module page_frame_bitmap_allocator_top_test;

  localparam logic [pfba_pkg::CfgW-1:0] MemMax = 26'd67104767;
  localparam int unsigned     StallLimit    = 3000;
  localparam int unsigned     DrainCycles   = 300;
  localparam int unsigned     Phases        = 10;
  localparam int unsigned     ItemsPerPhase = 110;

  // Tracker of the frame bitmap: own copy of map, row count and registers,
  // plus the queue of responses still owed by the block.
  class frame_map_tracker;
    bit [pfba_pkg::RowW-1:0]   bitmap [pfba_pkg::MaxRows];
    int unsigned               rows_in_use;
    logic [pfba_pkg::CfgW-1:0] mem_size;
    logic [pfba_pkg::CfgW-1:0] resv_end;
    pfba_pkg::rsp_t            expected_q [$];
    int unsigned               errors;

    function new();
      rows_in_use = 0;
      mem_size    = '0;
      resv_end    = '0;
      errors      = 0;
      foreach (bitmap[r]) bitmap[r] = '0;
    endfunction

    function void write_reg(logic [pfba_pkg::CfgIdxW-1:0] idx,
                            logic [pfba_pkg::CfgW-1:0] val);
      if (idx == pfba_pkg::CfgMemSize) begin
        mem_size = val;
      end else if (idx == pfba_pkg::CfgResvEnd) begin
        resv_end = val;
      end
    endfunction

    function int first_free();
      for (int r = 0; r < rows_in_use; r++) begin
        if (~bitmap[r] != '0) begin
          for (int c = 0; c < pfba_pkg::RowW; c++) begin
            if (!bitmap[r][c]) return r * pfba_pkg::RowW + c;
          end
        end
      end
      return -1;
    endfunction

    function bit set_frame(logic [pfba_pkg::FrameW-1:0] frame);
      int unsigned row;
      row = 32'(frame >> pfba_pkg::RowShift);
      if (row >= rows_in_use) return 1'b0;
      bitmap[row][frame[pfba_pkg::RowShift-1:0]] = 1'b1;
      return 1'b1;
    endfunction

    // Rows in use are cleared, whole rows of the reserved area set, then the
    // partial row; anything at or past the row count stays as it was.
    function void build_map();
      int unsigned frames;
      int unsigned rows;
      int unsigned used;
      int unsigned full;
      frames = (mem_size >> pfba_pkg::PageShift) + 1;
      rows   = (frames >> pfba_pkg::RowShift) + 1;
      if (rows > pfba_pkg::MaxRows) rows = pfba_pkg::MaxRows;
      rows_in_use = rows;
      used = (resv_end >> pfba_pkg::PageShift) + 1;
      if (resv_end[pfba_pkg::PageShift-1:0] != '0) used++;
      full = used >> pfba_pkg::RowShift;
      for (int unsigned r = 0; r < rows; r++) begin
        bitmap[r] = (r < full) ? {pfba_pkg::RowW{1'b1}} : {pfba_pkg::RowW{1'b0}};
      end
      if (full < rows) bitmap[full] = (64'd1 << (used % pfba_pkg::RowW)) - 64'd1;
    endfunction

    function void note_command(pfba_pkg::cmd_t c);
      pfba_pkg::rsp_t want;
      int             f;
      want = '0;
      case (c.func)
        pfba_pkg::FUNC_INIT: build_map();
        pfba_pkg::FUNC_FIND: begin
          f = first_free();
          if (f >= 0) begin
            want.frame_found = 1'b1;
            want.frame_index = f[pfba_pkg::FrameW-1:0];
          end
        end
        pfba_pkg::FUNC_MARK: want.ignored = !set_frame(c.frame_number);
        pfba_pkg::FUNC_MARK_ADDR: begin
          if (c.address >= pfba_pkg::AddrW'(mem_size)) begin
            want.ignored = 1'b1;
          end else begin
            want.ignored = !set_frame(
                c.address[pfba_pkg::PageShift+pfba_pkg::FrameW-1:pfba_pkg::PageShift]);
          end
        end
        default: want = '0;
      endcase
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(pfba_pkg::rsp_t got);
      pfba_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        report("response with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_found !== want.frame_found)
        report($sformatf("frame_found %b, want %b", got.frame_found, want.frame_found));
      if (got.frame_index !== want.frame_index)
        report($sformatf("frame_index %0d, want %0d", got.frame_index, want.frame_index));
      if (got.ignored !== want.ignored)
        report($sformatf("ignored %b, want %b", got.ignored, want.ignored));
    endtask

    task report_leftovers();
      if (expected_q.size() != 0)
        report($sformatf("%0d responses never arrived", expected_q.size()));
    endtask

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  pfba_pkg::cmd_t                cmd_i;
  logic                          done_o;
  pfba_pkg::rsp_t                rsp_o;
  logic                          cfg_we_i;
  logic [pfba_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pfba_pkg::CfgW-1:0]     cfg_wdata_i;

  frame_map_tracker    tracker = new();
  int unsigned         cmds_taken   = 0;
  int unsigned         quiet_cycles = 0;
  bit                  burst        = 1'b0;

  page_frame_bitmap_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor both channels at the rising edge. Check the response first so a
  // command transferred in the strobe cycle queues behind the one it follows.
  // Every posedge without a transfer on either channel counts towards the
  // watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(rsp_o);
    if (rst_ni && start && !busy) begin
      tracker.note_command(cmd_i);
      cmds_taken++;
    end
    if (rst_ni && (done_o || (start && !busy))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // Watchdog: give up once the block has gone silent for too long.
  // The slowest legal gap is a full-map init or find plus the longest idle.
  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("FAIL");
    $finish;
  end

  // Fill every field with noise; callers override the ones the operation uses.
  function automatic pfba_pkg::cmd_t noise_cmd(pfba_pkg::func_e f);
    pfba_pkg::cmd_t c;
    logic [63:0]    wide;
    wide           = {$urandom, $urandom};
    c.func         = f;
    c.frame_number = pfba_pkg::FrameW'($urandom_range(0, (1 << pfba_pkg::FrameW) - 1));
    c.address      = wide[pfba_pkg::AddrW-1:0];
    return c;
  endfunction

  // Present one command and hold it until it transfers. Keep start high
  // across back-to-back commands; drop it only when an idle gap is drawn.
  task automatic send_cmd(pfba_pkg::cmd_t c);
    int unsigned gap;
    int unsigned seen;
    if ($urandom_range(0, 24) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seen  = cmds_taken;
    start <= 1'b1;
    cmd_i <= c;
    wait (cmds_taken != seen);
  endtask

  task automatic send_op(pfba_pkg::func_e f);
    send_cmd(noise_cmd(f));
  endtask

  task automatic send_mark(logic [pfba_pkg::FrameW-1:0] frame);
    pfba_pkg::cmd_t c;
    c = noise_cmd(pfba_pkg::FUNC_MARK);
    c.frame_number = frame;
    send_cmd(c);
  endtask

  task automatic send_mark_addr(logic [pfba_pkg::AddrW-1:0] addr);
    pfba_pkg::cmd_t c;
    c = noise_cmd(pfba_pkg::FUNC_MARK_ADDR);
    c.address = addr;
    send_cmd(c);
  endtask

  // Drop start and wait for every owed response, then let the block settle.
  task automatic settle();
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges while the block is idle.
  task automatic apply_config(logic [pfba_pkg::CfgW-1:0] mem,
                              logic [pfba_pkg::CfgW-1:0] resv);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= pfba_pkg::CfgMemSize;
    cfg_wdata_i <= mem;
    @(posedge clk_i);
    tracker.write_reg(pfba_pkg::CfgMemSize, mem);
    cfg_idx_i   <= pfba_pkg::CfgResvEnd;
    cfg_wdata_i <= resv;
    @(posedge clk_i);
    tracker.write_reg(pfba_pkg::CfgResvEnd, resv);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed allocation traffic: find, then claim what was found,
  // with stray marks, out-of-range frames and addresses mixed in.
  function automatic pfba_pkg::cmd_t random_cmd();
    pfba_pkg::cmd_t c;
    int unsigned    roll;
    int unsigned    sel;
    int unsigned    lim;
    int             f;
    roll = $urandom_range(0, 99);
    sel  = $urandom_range(0, 3);
    f    = tracker.first_free();
    lim  = 32'(tracker.mem_size);
    if (roll < 6) begin
      c = noise_cmd(pfba_pkg::FUNC_INIT);
    end else if (roll < 36) begin
      c = noise_cmd(pfba_pkg::FUNC_FIND);
    end else if (roll < 70) begin
      c = noise_cmd(pfba_pkg::FUNC_MARK);
      if (sel < 2 && f >= 0) begin
        c.frame_number = f[pfba_pkg::FrameW-1:0];
      end else if (sel < 3 && tracker.rows_in_use != 0) begin
        c.frame_number = pfba_pkg::FrameW'(
            $urandom_range(0, tracker.rows_in_use * pfba_pkg::RowW - 1));
      end
    end else begin
      c = noise_cmd(pfba_pkg::FUNC_MARK_ADDR);
      if (sel == 0 && f >= 0) begin
        c.address = pfba_pkg::AddrW'((f << pfba_pkg::PageShift)
                    + $urandom_range(0, (1 << pfba_pkg::PageShift) - 1));
      end else if (sel == 1 && lim != 0) begin
        c.address = pfba_pkg::AddrW'($urandom_range(0, lim - 1));
      end else if (sel == 2) begin
        // straddle the top of memory: the size itself and just past it
        c.address = pfba_pkg::AddrW'(lim + $urandom_range(0, 3));
      end
    end
    return c;
  endfunction

  task automatic run_directed();
    // No rows yet: find reports nothing, marks are dropped.
    send_op(pfba_pkg::FUNC_FIND);
    send_mark('0);
    send_mark_addr('0);
    // Smallest map: one row, frame 0 reserved.
    send_op(pfba_pkg::FUNC_INIT);
    send_op(pfba_pkg::FUNC_FIND);
    send_mark(14'd63);
    send_mark(14'd64);
    send_mark({pfba_pkg::FrameW{1'b1}});
    send_mark_addr({pfba_pkg::AddrW{1'b1}});
    // Largest map: every row in use; probe the top frame and memory boundary.
    apply_config(MemMax, '0);
    send_op(pfba_pkg::FUNC_INIT);
    send_mark_addr(pfba_pkg::AddrW'(MemMax));
    send_mark_addr(pfba_pkg::AddrW'(MemMax - 26'd1));
    send_mark({pfba_pkg::FrameW{1'b1}});
    send_op(pfba_pkg::FUNC_FIND);
    // Reserved end on a page boundary, then one byte past it.
    apply_config(MemMax, 26'd4096);
    send_op(pfba_pkg::FUNC_INIT);
    send_op(pfba_pkg::FUNC_FIND);
    apply_config(MemMax, 26'd4097);
    send_op(pfba_pkg::FUNC_INIT);
    send_op(pfba_pkg::FUNC_FIND);
    // Reserved area filling exactly the single row: nothing free.
    apply_config('0, 26'd258048);
    send_op(pfba_pkg::FUNC_INIT);
    send_op(pfba_pkg::FUNC_FIND);
    // Reserved area reaching the end of the last row: the whole map used, longest find.
    apply_config(MemMax, MemMax);
    send_op(pfba_pkg::FUNC_INIT);
    send_op(pfba_pkg::FUNC_FIND);
    send_mark('0);
    send_mark_addr(40'hA5_5A00_1234);
  endtask

  initial begin
    logic [pfba_pkg::CfgW-1:0] mem;
    logic [pfba_pkg::CfgW-1:0] resv;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= pfba_pkg::CfgMemSize;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random phases: the extremes first, then mostly small maps so that
    // init and find stay short, with the odd full-size map.
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       begin mem = '0;     resv = '0;     end
        1:       begin mem = MemMax; resv = MemMax; end
        2:       begin mem = MemMax; resv = '0;     end
        3:       begin mem = '0;     resv = MemMax; end
        default: begin
          mem = ($urandom_range(0, 3) == 0) ? pfba_pkg::CfgW'($urandom_range(0, MemMax))
                                            : pfba_pkg::CfgW'($urandom_range(0, 1 << 20));
          if ($urandom_range(0, 1) == 0) begin
            resv = pfba_pkg::CfgW'(($urandom_range(0, mem) >> pfba_pkg::PageShift)
                                   << pfba_pkg::PageShift);
          end else begin
            resv = pfba_pkg::CfgW'($urandom_range(0, MemMax));
          end
        end
      endcase
      apply_config(mem, resv);
      send_op(pfba_pkg::FUNC_INIT);
      repeat (ItemsPerPhase) send_cmd(random_cmd());
    end

    // Let the last responses drain, then hold a little longer for strays.
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    tracker.report_leftovers();
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[page_frame_bitmap_allocator_top.f]
sv/pfba_pkg.sv
sv/pfba_map_ram.sv
sv/pfba_ctrl.sv
sv/page_frame_bitmap_allocator_top.sv
tb/sv/page_frame_bitmap_allocator_top_test.sv
